// ===== rtl/slvf_pkg.sv =====
// Shared types, field layout and register codes for the shape label vote filter.
package slvf_pkg;

	localparam int NUM_CLASSES = 4;
	localparam int PROB_W = 16;
	localparam int POSE_W = 17;
	localparam int VOTE_CFG_W = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;
	localparam int IN_DATA_W = 104;
	localparam int OUT_DATA_W = 8;
	localparam int ALPHA_LSB = NUM_CLASSES * PROB_W;
	localparam int BETA_LSB = ALPHA_LSB + POSE_W;

	typedef logic [PROB_W-1:0] prob_t;
	typedef logic signed [POSE_W-1:0] pose_t;
	typedef logic [NUM_CLASSES-1:0] class_vec_t;
	typedef logic [VOTE_CFG_W-1:0] votes_cfg_t;

	typedef enum logic [1:0] {
		STATUS_FOUND = 2'd0,
		STATUS_NONE  = 2'd1,
		STATUS_POSE  = 2'd2
	} status_t;

	typedef struct packed {
		class_vec_t raw;
		logic       pose_ok;
	} class_res_t;

	localparam logic [CFG_IDX_W-1:0] REG_THRESH_ELLIPSE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_ROUND    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_SQUARE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESH_TRIANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POSE_LIMIT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_VOTES       = 3'd5;

	localparam prob_t RST_THRESH_ELLIPSE  = 16'd45875;
	localparam prob_t RST_THRESH_ROUND    = 16'd45875;
	localparam prob_t RST_THRESH_SQUARE   = 16'd49152;
	localparam prob_t RST_THRESH_TRIANGLE = 16'd58982;
	localparam pose_t RST_POSE_LIMIT      = 17'sd7680;
	localparam votes_cfg_t RST_MIN_VOTES  = 3'd2;

endpackage

// ===== rtl/shape_label_vote_filter.sv =====
// Top level: k-of-n vote filter for face shape labels over a sliding frame window.
// A face beat accepted into the input register moves on to the result register once that one is free or being read.
// Throughput: one beat per cycle while the output is not stalled; the input register and result register overlap items.
// A no-face beat clears the history in its compute cycle and produces no result beat.
// Reset clears the history, the fill count and both valid flags, and loads register defaults.
module shape_label_vote_filter
	import slvf_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// prob_ellipse, prob_round, prob_square, prob_triangle, pose_alpha, pose_beta, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// label_ellipse, label_round, label_square, label_triangle, status, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	prob_t      thresh_q [NUM_CLASSES];
	pose_t      pose_limit_q;
	votes_cfg_t min_votes_q;

	logic       valid_s1;
	logic       func_s1;
	prob_t      prob_s1 [NUM_CLASSES];
	pose_t      alpha_s1;
	pose_t      beta_s1;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic       advance;
	class_res_t cls;
	class_vec_t labels;
	status_t    status;

	assign cfg_ready = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q[0] <= RST_THRESH_ELLIPSE;
			thresh_q[1] <= RST_THRESH_ROUND;
			thresh_q[2] <= RST_THRESH_SQUARE;
			thresh_q[3] <= RST_THRESH_TRIANGLE;
			pose_limit_q <= RST_POSE_LIMIT;
			min_votes_q <= RST_MIN_VOTES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_THRESH_ELLIPSE: thresh_q[0] <= cfg_data[PROB_W-1:0];
				REG_THRESH_ROUND: thresh_q[1] <= cfg_data[PROB_W-1:0];
				REG_THRESH_SQUARE: thresh_q[2] <= cfg_data[PROB_W-1:0];
				REG_THRESH_TRIANGLE: thresh_q[3] <= cfg_data[PROB_W-1:0];
				REG_POSE_LIMIT: pose_limit_q <= pose_t'(cfg_data);
				REG_MIN_VOTES: min_votes_q <= cfg_data[VOTE_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1 <= s_tuser[0];
			for (int c = 0; c < NUM_CLASSES; c++) begin
				prob_s1[c] <= s_tdata[c*PROB_W +: PROB_W];
			end
			alpha_s1 <= s_tdata[ALPHA_LSB +: POSE_W];
			beta_s1 <= s_tdata[BETA_LSB +: POSE_W];
		end
	end

	slvf_classify u_classify (
		.prob       (prob_s1),
		.thresh     (thresh_q),
		.pose_alpha (alpha_s1),
		.pose_beta  (beta_s1),
		.pose_limit (pose_limit_q),
		.res        (cls)
	);

	slvf_vote #(
		.WINDOW (WINDOW)
	) u_vote (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (advance && !func_s1),
		.clr       (advance && func_s1),
		.raw       (cls.raw),
		.min_votes (min_votes_q),
		.labels    (labels)
	);

	always_comb begin
		if (!cls.pose_ok) begin
			status = STATUS_POSE;
		end else if (labels != '0) begin
			status = STATUS_FOUND;
		end else begin
			status = STATUS_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && !func_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && !func_s1) begin
			out_data_q <= {(OUT_DATA_W - NUM_CLASSES - 2)'(0), status, labels};
		end
	end

endmodule

// ===== rtl/slvf_classify.sv =====
// Threshold compare of the class probabilities and pose range check.
module slvf_classify
	import slvf_pkg::*;
(
	input  prob_t      prob [NUM_CLASSES],
	input  prob_t      thresh [NUM_CLASSES],
	input  pose_t      pose_alpha,
	input  pose_t      pose_beta,
	input  pose_t      pose_limit,
	output class_res_t res
);

	always_comb begin
		for (int c = 0; c < NUM_CLASSES; c++) begin
			res.raw[c] = prob[c] > thresh[c];
		end
		res.pose_ok = (pose_alpha < pose_limit) && (pose_beta < pose_limit);
	end

endmodule

// ===== rtl/slvf_vote.sv =====
// Frame history, per-class vote count and label decision.
module slvf_vote
	import slvf_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       upd,
	input  logic       clr,
	input  class_vec_t raw,
	input  votes_cfg_t min_votes,
	output class_vec_t labels
);

	localparam int FW = $clog2(WINDOW + 1);
	localparam int CMP_W = (FW > VOTE_CFG_W) ? FW : VOTE_CFG_W;

	class_vec_t hist_q [WINDOW];
	class_vec_t hist_next [WINDOW];
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_next;
	logic [FW-1:0] votes [NUM_CLASSES];
	class_vec_t voted;

	always_comb begin
		hist_next[0] = raw;
		for (int k = 1; k < WINDOW; k++) begin
			hist_next[k] = hist_q[k-1];
		end
		fill_next = (fill_q == FW'(WINDOW)) ? fill_q : fill_q + 1'b1;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			votes[c] = '0;
			for (int k = 0; k < WINDOW; k++) begin
				votes[c] = votes[c] + FW'(hist_next[k][c]);
			end
			voted[c] = CMP_W'(votes[c]) >= CMP_W'(min_votes);
		end
		labels = ((voted == '0) && (fill_next == FW'(1))) ? raw : voted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			for (int k = 0; k < WINDOW; k++) begin
				hist_q[k] <= '0;
			end
		end else if (clr) begin
			fill_q <= '0;
			for (int k = 0; k < WINDOW; k++) begin
				hist_q[k] <= '0;
			end
		end else if (upd) begin
			fill_q <= fill_next;
			for (int k = 0; k < WINDOW; k++) begin
				hist_q[k] <= hist_next[k];
			end
		end
	end

endmodule

// ===== rtl/slvf_checker.sv =====
// Port-level checks for the shape label vote filter and their binding.
module slvf_checker
	import slvf_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [0:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Result beat changed while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[5:4] != 2'd3)
		else $error("Unused status code on output.");

	a_status_labels: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5:4] != STATUS_POSE |->
		((m_tdata[3:0] != 4'd0) == (m_tdata[5:4] == STATUS_FOUND)))
		else $error("Status disagrees with labels.");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[0] == 1'b0), 2))
		else $error("Result beat without an accepted face beat.");

endmodule

bind shape_label_vote_filter slvf_checker u_slvf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/shape_label_vote_filter_check.sv =====
// Checker that predicts every result beat of the shape label vote filter and compares it.
module shape_label_vote_filter_check
	import slvf_pkg::*;
#(
	parameter int WINDOW = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	// prob_ellipse, prob_round, prob_square, prob_triangle, pose_alpha, pose_beta, zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func
	input  logic [0:0]            s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// label_ellipse, label_round, label_square, label_triangle, status, zero fill
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		class_vec_t labels;
		status_t    status;
	} shape_result_t;

	string label_name [NUM_CLASSES] = '{"label_ellipse", "label_round", "label_square",
		"label_triangle"};

	prob_t         thresh_q [NUM_CLASSES];
	pose_t         pose_lim;
	votes_cfg_t    vote_min;
	class_vec_t    frame_hist [WINDOW];
	int            hist_fill;
	shape_result_t label_q [$];

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	function automatic shape_result_t vote_frame(input logic [IN_DATA_W-1:0] beat);
		class_vec_t    raw;
		shape_result_t res;
		int            votes;
		pose_t         alpha;
		pose_t         beta;
		raw = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			raw[c] = beat[c*PROB_W +: PROB_W] > thresh_q[c];
		end
		for (int k = WINDOW - 1; k > 0; k--) begin
			frame_hist[k] = frame_hist[k-1];
		end
		frame_hist[0] = raw;
		if (hist_fill < WINDOW) begin
			hist_fill++;
		end
		res.labels = '0;
		for (int c = 0; c < NUM_CLASSES; c++) begin
			votes = 0;
			for (int k = 0; k < hist_fill; k++) begin
				votes += int'(frame_hist[k][c]);
			end
			res.labels[c] = votes >= int'(vote_min);
		end
		// A lone stored frame falls back to its own raw bits when voting set nothing.
		if (res.labels == '0 && hist_fill == 1) begin
			res.labels = raw;
		end
		alpha = beat[ALPHA_LSB +: POSE_W];
		beta = beat[BETA_LSB +: POSE_W];
		if (alpha < pose_lim && beta < pose_lim) begin
			res.status = (res.labels != '0) ? STATUS_FOUND : STATUS_NONE;
		end else begin
			res.status = STATUS_POSE;
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shape_result_t want;
		if (!arst_n) begin
			thresh_q[0] = RST_THRESH_ELLIPSE;
			thresh_q[1] = RST_THRESH_ROUND;
			thresh_q[2] = RST_THRESH_SQUARE;
			thresh_q[3] = RST_THRESH_TRIANGLE;
			pose_lim = RST_POSE_LIMIT;
			vote_min = RST_MIN_VOTES;
			for (int k = 0; k < WINDOW; k++) begin
				frame_hist[k] = '0;
			end
			hist_fill = 0;
			label_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (label_q.size() == 0) begin
					report("result beat with nothing outstanding", int'(m_tdata), -1);
				end else begin
					want = label_q[0];
					label_q.delete(0);
					for (int c = 0; c < NUM_CLASSES; c++) begin
						if (m_tdata[c] !== want.labels[c]) begin
							report(label_name[c], int'(m_tdata[c]), int'(want.labels[c]));
						end
					end
					if (m_tdata[NUM_CLASSES +: 2] !== want.status) begin
						report("status", int'(m_tdata[NUM_CLASSES +: 2]), int'(want.status));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESH_ELLIPSE, REG_THRESH_ROUND, REG_THRESH_SQUARE,
					REG_THRESH_TRIANGLE: begin
						thresh_q[cfg_index[1:0]] = cfg_data[PROB_W-1:0];
					end
					REG_POSE_LIMIT: begin
						pose_lim = cfg_data[POSE_W-1:0];
					end
					REG_MIN_VOTES: begin
						vote_min = cfg_data[VOTE_CFG_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready) begin
				// A no-face beat empties the window and yields no result.
				if (s_tuser[0]) begin
					for (int k = 0; k < WINDOW; k++) begin
						frame_hist[k] = '0;
					end
					hist_fill = 0;
				end else begin
					label_q.insert(label_q.size(), vote_frame(s_tdata));
				end
			end
			pending <= label_q.size();
		end
	end

endmodule

// ===== tb/shape_label_vote_filter_test.sv =====
// Testbench top for the shape label vote filter: frames, register settings, stalls and verdict.
module shape_label_vote_filter_test;
	import slvf_pkg::*;

	localparam logic FUNC_FACE     = 1'b0;
	localparam logic FUNC_NO_FACE  = 1'b1;
	localparam int   RANDOM_PHASES = 8;
	localparam int   PHASE_FRAMES  = 160;
	localparam int   DRAIN_CYCLES  = 4;
	localparam int   MAX_GAP       = 13;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    fail_count;
	int                    pending;
	logic                  calm = 1'b0;
	prob_t                 thr_now [NUM_CLASSES];
	pose_t                 lim_now;

	always #6 clk = ~clk;

	shape_label_vote_filter i_dut (.*);

	shape_label_vote_filter_check i_check (.*);

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_frame(input prob_t e, input prob_t r,
		input prob_t sq, input prob_t t, input pose_t a, input pose_t b);
		logic [IN_DATA_W-1:0] beat;
		beat = '0;
		beat[0*PROB_W +: PROB_W] = e;
		beat[1*PROB_W +: PROB_W] = r;
		beat[2*PROB_W +: PROB_W] = sq;
		beat[3*PROB_W +: PROB_W] = t;
		beat[ALPHA_LSB +: POSE_W] = a;
		beat[BETA_LSB +: POSE_W] = b;
		return beat;
	endfunction

	function automatic prob_t draw_prob(input prob_t thr);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2, 3: return thr + prob_t'($urandom_range(0, 4)) - prob_t'(2);
			default: return prob_t'($urandom);
		endcase
	endfunction

	function automatic pose_t draw_pose(input pose_t lim);
		case ($urandom_range(0, 7))
			0: return pose_t'($urandom);
			1: return lim + pose_t'($urandom_range(0, 2)) - pose_t'(1);
			2: return $urandom_range(0, 1) ? pose_t'(46080) : pose_t'(-46080);
			default: return lim - pose_t'($urandom_range(1, 9000));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_thresh_word();
		logic [CFG_DATA_W-1:0] word;
		case ($urandom_range(0, 4))
			0: word = '0;
			1: word = 17'h0FFFF;
			default: word = CFG_DATA_W'($urandom_range(20000, 65000));
		endcase
		word[PROB_W] = 1'($urandom_range(0, 1));
		return word;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_limit_word();
		case ($urandom_range(0, 7))
			0: return 17'h10000;
			1: return 17'h0FFFF;
			2: return pose_t'(-46080);
			3: return pose_t'(46080);
			default: return pose_t'(int'($urandom_range(0, 92160)) - 46080);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_votes_word();
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[VOTE_CFG_W-1:0] = ($urandom_range(0, 3) == 0) ?
			VOTE_CFG_W'($urandom_range(0, 7)) : VOTE_CFG_W'($urandom_range(1, 5));
		return word;
	endfunction

	task automatic send_beat(input logic func, input logic [IN_DATA_W-1:0] data);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic face(input prob_t e, input prob_t r, input prob_t sq, input prob_t t,
		input pose_t a, input pose_t b);
		send_beat(FUNC_FACE, pack_frame(e, r, sq, t, a, b));
	endtask

	task automatic no_face();
		send_beat(FUNC_NO_FACE, pack_frame(prob_t'($urandom), prob_t'($urandom),
			prob_t'($urandom), prob_t'($urandom), pose_t'($urandom), pose_t'($urandom)));
	endtask

	task automatic random_face();
		face(draw_prob(thr_now[0]), draw_prob(thr_now[1]), draw_prob(thr_now[2]),
			draw_prob(thr_now[3]), draw_pose(lim_now), draw_pose(lim_now));
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_THRESH_ELLIPSE, REG_THRESH_ROUND, REG_THRESH_SQUARE,
			REG_THRESH_TRIANGLE: begin
				thr_now[idx[1:0]] = data[PROB_W-1:0];
			end
			REG_POSE_LIMIT: begin
				lim_now = data[POSE_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic load_config(input logic [CFG_DATA_W-1:0] e, input logic [CFG_DATA_W-1:0] r,
		input logic [CFG_DATA_W-1:0] sq, input logic [CFG_DATA_W-1:0] t,
		input logic [CFG_DATA_W-1:0] lim, input logic [CFG_DATA_W-1:0] votes, input logic junk);
		write_reg(REG_THRESH_ELLIPSE, e);
		write_reg(REG_THRESH_ROUND, r);
		write_reg(REG_THRESH_SQUARE, sq);
		write_reg(REG_THRESH_TRIANGLE, t);
		write_reg(REG_POSE_LIMIT, lim);
		write_reg(REG_MIN_VOTES, votes);
		// Indexes past the last register must leave every setting alone.
		if (junk) begin
			write_reg(REG_MIN_VOTES + 3'd1, CFG_DATA_W'($urandom));
			write_reg(REG_MIN_VOTES + 3'd2, CFG_DATA_W'($urandom));
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = draw_gap();
			if (gap == 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				m_tready <= 1'b1;
			end
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	initial begin
		#(12 * 600000);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		thr_now = '{RST_THRESH_ELLIPSE, RST_THRESH_ROUND, RST_THRESH_SQUARE, RST_THRESH_TRIANGLE};
		lim_now = RST_POSE_LIMIT;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Defaults after reset: lone-frame fallback, thresholds hit exactly, pose edges.
		face('1, '1, '1, '1, '0, '0);
		face('0, '0, '0, '0, '0, '0);
		face(RST_THRESH_ELLIPSE, RST_THRESH_ROUND, RST_THRESH_SQUARE, RST_THRESH_TRIANGLE,
			'0, '0);
		face(RST_THRESH_ELLIPSE + 16'd1, RST_THRESH_ROUND + 16'd1, RST_THRESH_SQUARE + 16'd1,
			RST_THRESH_TRIANGLE + 16'd1, RST_POSE_LIMIT - 17'sd1, RST_POSE_LIMIT - 17'sd1);
		face('1, '1, '1, '1, RST_POSE_LIMIT, '0);
		face('1, '0, '0, '0, '0, RST_POSE_LIMIT);
		face('0, '1, '0, '0, pose_t'(-46080), pose_t'(46080));
		face('0, '0, '1, '0, 17'h10000, 17'h10000);
		face('0, '0, '0, '1, 17'h0FFFF, '0);
		face(prob_t'($urandom), prob_t'($urandom), prob_t'($urandom), prob_t'($urandom),
			'0, '0);
		no_face();
		face('0, '0, '0, '0, '0, '0);
		no_face();
		face('1, '0, '1, '0, '0, '0);
		face('1, '0, '0, '0, '0, '0);
		drain();

		// Zero votes needed: every label is set even with no raw bit.
		load_config(17'h0FFFF, 17'h0FFFF, 17'h1FFFF, 17'h0FFFF, pose_t'(46080), 17'd0, 1'b1);
		face('1, '1, '1, '1, '0, '0);
		no_face();
		face('0, '0, '0, '0, pose_t'(46079), pose_t'(-46080));
		drain();

		// More votes than the window holds: only the lone-frame fallback can set labels.
		load_config(17'd0, 17'd0, 17'h10000, 17'd0, pose_t'(-46080), 17'h1FFFF, 1'b0);
		face(16'd1, 16'd1, 16'd1, 16'd1, 17'h10000, 17'h10000);
		face('0, '0, '0, '0, 17'h10000, 17'h10000);
		face('1, '1, '1, '1, 17'h10000, 17'h10000);
		drain();

		// A full window with every pose out of range.
		load_config(CFG_DATA_W'(RST_THRESH_ELLIPSE), CFG_DATA_W'(RST_THRESH_ROUND),
			CFG_DATA_W'(RST_THRESH_SQUARE), CFG_DATA_W'(RST_THRESH_TRIANGLE), 17'h10000,
			17'd5, 1'b0);
		repeat (6) face('1, '1, '1, '1, '0, 17'h0FFFF);
		drain();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			load_config(draw_thresh_word(), draw_thresh_word(), draw_thresh_word(),
				draw_thresh_word(), draw_limit_word(), draw_votes_word(),
				$urandom_range(0, 3) == 0);
			calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_FRAMES; n++) begin
				if ($urandom_range(0, 19) == 0) begin
					no_face();
				end else begin
					random_face();
				end
			end
			drain();
		end

		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/slvf_pkg.sv
rtl/slvf_classify.sv
rtl/slvf_vote.sv
rtl/shape_label_vote_filter.sv
rtl/slvf_checker.sv
tb/shape_label_vote_filter_check.sv
tb/shape_label_vote_filter_test.sv
